>>> sv/arx_tag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arx_tag_pkg
// Shared constants, types and the round function of the message tag pipeline.
// ----------------------------------------------------------------------------
package arx_tag_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned TagW       = 16;
  localparam int unsigned NumKeys    = 4;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned RoundCount = 59;
  localparam int unsigned RotA       = 7;
  localparam int unsigned RotB       = 11;

  // Round schedule, bit j picks the form of round j; upper bits are zero.
  localparam logic [63:0] Schedule = 64'h000A_D5A6_B4D2_E1F0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY0 = 2'd0,
    CFG_KEY1 = 2'd1,
    CFG_KEY2 = 2'd2,
    CFG_KEY3 = 2'd3
  } cfg_idx_e;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    word_t s3;
    word_t s2;
    word_t s1;
    word_t s0;
  } arx_state_t;

  function automatic word_t rotl(input word_t x, input int unsigned n);
    rotl = (x << n) | (x >> (WordW - n));
  endfunction

  // One shift of the four-word state; sel chooses the rotl-7 form.
  function automatic arx_state_t round_step(input arx_state_t st, input logic sel);
    arx_state_t r;
    word_t      t;
    if (sel) begin
      t = st.s0 ^ rotl(st.s1 + st.s2, RotA);
    end else begin
      t = st.s0 ^ rotl(st.s2 + st.s3, RotB);
    end
    r.s0 = st.s1;
    r.s1 = st.s2;
    r.s2 = st.s3;
    r.s3 = t;
    return r;
  endfunction

endpackage

>>> sv/arx_message_tag.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arx_message_tag
// Keyed 16-bit tag over a 128-bit message block, one round per pipe stage.
// ----------------------------------------------------------------------------
// Accepts one block per clock and returns one tag per block, in order. The
// key is whitened into the block in the input stage, then every ARX round
// sits in its own register stage; a tag passes the input stage and then each
// round stage in turn before it is valid on the output. The whole pipe
// advances together: a stall on the result side holds every stage and drops
// s_axis_tready until the waiting tag is taken. Each round stage holds one
// 32-bit add, a fixed rotate and an XOR. Key registers must be written
// through the plain write port only while no block is in flight; the block
// itself does not enforce it.
module arx_message_tag #(
  parameter int unsigned ROUND_COUNT = arx_tag_pkg::RoundCount
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [arx_tag_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [arx_tag_pkg::WordW-1:0]      cfg_wdata_i,
  // block input
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [4*arx_tag_pkg::WordW-1:0]    s_axis_tdata,  // msg_word0..msg_word3
  // tag output
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [arx_tag_pkg::TagW-1:0]       m_axis_tdata   // tag_value
);
  import arx_tag_pkg::*;

  word_t key_q [NumKeys];

  arx_state_t st_q  [ROUND_COUNT+1];
  logic       vld_q [ROUND_COUNT+1];
  logic       adv;

  // Hold everything while the finished tag waits.
  assign adv           = !vld_q[ROUND_COUNT] || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumKeys; k++) begin
        key_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY0: key_q[0] <= cfg_wdata_i;
        CFG_KEY1: key_q[1] <= cfg_wdata_i;
        CFG_KEY2: key_q[2] <= cfg_wdata_i;
        CFG_KEY3: key_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input stage: key whitening.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid) begin
      st_q[0].s0 <= s_axis_tdata[0*WordW +: WordW] ^ key_q[0];
      st_q[0].s1 <= s_axis_tdata[1*WordW +: WordW] ^ key_q[1];
      st_q[0].s2 <= s_axis_tdata[2*WordW +: WordW] ^ key_q[2];
      st_q[0].s3 <= s_axis_tdata[3*WordW +: WordW] ^ key_q[3];
    end
  end

  // Round stages, one round each.
  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
    localparam logic Sel = Schedule[g];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (adv) begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv && vld_q[g]) begin
        st_q[g+1] <= round_step(st_q[g], Sel);
      end
    end
  end

  assign m_axis_tvalid = vld_q[ROUND_COUNT];
  assign m_axis_tdata  = st_q[ROUND_COUNT].s3[TagW-1:0] ^ key_q[3][TagW-1:0];

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyed 16-bit message tag pipeline.
// ----------------------------------------------------------------------------
// Blocks of four message words go in on the slave stream and tags come back
// on the master stream. Each accepted block is scored against a local tag
// predictor that uses the key values last written through the config port.
// The run covers directed corner blocks, random traffic under three idle
// patterns and several key settings, and a long result-side stall that backs
// the pipe up to the input.
// ----------------------------------------------------------------------------
module testbench;
  import arx_tag_pkg::*;

  localparam int StallLimit = 2000;   // cycles with no beat on either side
  localparam int LongHold   = 400;

  // Four words, word 0 in the low bits; used for blocks and for key sets.
  typedef struct packed {
    word_t w3;
    word_t w2;
    word_t w1;
    word_t w0;
  } quad_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [WordW-1:0]    cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [4*WordW-1:0]  s_axis_tdata = '0;  // msg_word0..msg_word3
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TagW-1:0]     m_axis_tdata;       // tag_value

  quad_t               key_shadow = '0;
  logic [TagW-1:0]     tag_q[$];
  int unsigned         src_idle_pct = 0;
  int unsigned         sink_idle_pct = 0;
  int unsigned         sink_hold_left = 0;
  int unsigned         mismatch_count = 0;
  int unsigned         quiet_cycles = 0;

  arx_message_tag i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [TagW-1:0] predict_tag(input quad_t blk);
    word_t a, b, c, d, sum, t;
    a = blk.w0 ^ key_shadow.w0;
    b = blk.w1 ^ key_shadow.w1;
    c = blk.w2 ^ key_shadow.w2;
    d = blk.w3 ^ key_shadow.w3;
    for (int j = 0; j < RoundCount; j++) begin
      // schedule bits past 55 are zero, so the last rounds take the rotl-11 form
      if (Schedule[j]) begin
        sum = b + c;
        t   = a ^ ((sum << RotA) | (sum >> (WordW - RotA)));
      end else begin
        sum = c + d;
        t   = a ^ ((sum << RotB) | (sum >> (WordW - RotB)));
      end
      a = b;
      b = c;
      c = d;
      d = t;
    end
    return d[TagW-1:0] ^ key_shadow.w3[TagW-1:0];
  endfunction

  // Mostly uniform, with a bias toward all-zero and all-one words.
  function automatic word_t rand_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic quad_t rand_quad();
    return '{rand_word(), rand_word(), rand_word(), rand_word()};
  endfunction

  task automatic send_block(input quad_t blk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= blk;
    do @(posedge clk_i); while (!s_axis_tready);
    tag_q.push_back(predict_tag(blk));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tag_q.size() != 0) @(posedge clk_i);
  endtask

  // Only called with the pipe empty.
  task automatic load_keys(input quad_t keys);
    for (int i = 0; i < NumKeys; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= cfg_idx_e'(i);
      cfg_wdata_i <= keys[i*WordW +: WordW];
      @(posedge clk_i);
    end
    cfg_we_i   <= 1'b0;
    key_shadow  = keys;
  endtask

  task automatic send_corner_blocks();
    send_block('0);
    send_block('1);
    send_block({4{32'h8000_0000}});
    send_block({4{32'h0000_0001}});
    send_block({32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA});
    // adds that wrap past 2^32
    send_block({32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF});
    send_block({32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000});
  endtask

  task automatic test_directed();
    src_idle_pct  = 28;
    sink_idle_pct = 68;
    send_corner_blocks();
    wait_drained();
    load_keys('1);
    send_corner_blocks();
    wait_drained();
    load_keys({32'h0000_FFFF, 32'hFFFF_0000, 32'h8000_0001, 32'h7FFF_FFFE});
    send_corner_blocks();
    send_block({32'h0000_FFFF, 32'hFFFF_0000, 32'h8000_0001, 32'h7FFF_FFFE});
    wait_drained();
  endtask

  task automatic test_random(input int unsigned n_items, input int unsigned src_pct,
                             input int unsigned sink_pct, input quad_t keys);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    load_keys(keys);
    repeat (n_items) send_block(rand_quad());
    wait_drained();
  endtask

  // Hold the result side off so the pipe fills and drops s_axis_tready.
  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_idle_pct  = 0;
    load_keys(rand_quad());
    sink_hold_left = LongHold;
    repeat (150) send_block(rand_quad());
    wait_drained();
  endtask

  // Result side: score each beat, then pick tready for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tag_q.size() == 0) begin
        $display("%0t: unexpected tag beat, expected none, actual %h",
                 $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        if (m_axis_tdata !== tag_q[0]) begin
          $display("%0t: tag_value mismatch, expected %h, actual %h",
                   $time, tag_q[0], m_axis_tdata);
          mismatch_count++;
        end
        void'(tag_q.pop_front());
      end
    end
    if (sink_hold_left != 0) begin
      m_axis_tready  <= 1'b0;
      sink_hold_left -= 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(650, 28, 68, rand_quad());
    test_random(650, 68, 28, '0);
    test_backpressure();
    test_random(650, 0, 0, rand_quad());
    repeat (RoundCount + 8) @(posedge clk_i);
    if (mismatch_count == 0 && tag_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> arx_message_tag.f
sv/arx_tag_pkg.sv
sv/arx_message_tag.sv
tb/sv/testbench.sv
